// File: design/vcpc_pkg.sv
// vcpc_pkg: shared constants, register codes, fsm states and control structs
// for the view cone point counter
// depends on nothing
package vcpc_pkg;

    localparam int MAX_POINTS = 64;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int IDX_W      = 6;
    localparam int CNT_W      = 7;
    localparam int COORD_W    = 16;
    localparam int SIN_W      = 15;
    localparam int RAD_W      = 32;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 2;

    // offset, product, rotated edge, cross product, square and distance widths
    localparam int OFS_W   = COORD_W + 1;
    localparam int PROD_W  = 2 * COORD_W;
    localparam int EDGE_W  = PROD_W + 1;
    localparam int CROSS_W = EDGE_W + OFS_W;
    localparam int SQ_W    = 2 * OFS_W;
    localparam int D2_W    = RAD_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_HALF   = 2'd0,
        REG_SIN_HALF   = 2'd1,
        REG_RADIUS_SQ  = 2'd2,
        REG_POINT_CNT  = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_QUERY = 1'b1
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROT_MUL,
        ST_ROT_SUM,
        ST_SWEEP,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              wr_point;
        logic              load_query;
        logic              rot_mul;
        logic              rot_sum;
        logic              clear_count;
        logic              issue;
        logic [ADDR_W-1:0] rd_addr;
        logic              load_out;
    } vcpc_cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] limit;
        logic             pipe_busy;
        logic             out_free;
    } vcpc_sts_t;

endpackage

// File: design/view_cone_point_counter.sv
// view_cone_point_counter: top level, counts stored points inside a view sector
// depends on vcpc_pkg, vcpc_ctrl and vcpc_dp
//
//   channel   direction   handshake            payload
//   s_        in          s_valid / s_ready    req_type, point_index, coord, dir
//   m_        out         m_valid / m_ready    visible_count
//   cfg_      in          cfg_wr_en            cfg_index, cfg_wdata
//
// a point write is accepted and written in the same edge
// a query walks limit = min(point_count, 64) stored points, one per cycle through
// the single read port of the point memory, after rotation setup and before a four
// stage drain of the distance and cross product pipeline; with limit zero the walk
// is skipped, and no item is accepted until the count goes to the result register
// reset is synchronous, clears control and loads the register defaults; the point
// table is not cleared
// the result register holds the count until m_ready; a query that finishes while
// the previous count is still waiting holds in its final state
module view_cone_point_counter (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [vcpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vcpc_pkg::CFG_W-1:0]           cfg_wdata,

    // request items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic [vcpc_pkg::IDX_W-1:0]           s_point_index,
    input  logic signed [vcpc_pkg::COORD_W-1:0]  s_coord_x,
    input  logic signed [vcpc_pkg::COORD_W-1:0]  s_coord_y,
    input  logic signed [vcpc_pkg::COORD_W-1:0]  s_dir_x,
    input  logic signed [vcpc_pkg::COORD_W-1:0]  s_dir_y,

    // count result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [vcpc_pkg::CNT_W-1:0]           m_visible_count
);

    // command and status between sequencer and datapath
    vcpc_pkg::vcpc_cmd_t cmd;
    vcpc_pkg::vcpc_sts_t sts;

    // sequencer: accepts items, walks the table, hands the count to the output
    vcpc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_point_index (s_point_index),
        .sts           (sts),
        .cmd           (cmd)
    );

    // datapath: registers, point memory, edge rotation, per-point tests, counter
    vcpc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_point_index   (s_point_index),
        .s_coord_x       (s_coord_x),
        .s_coord_y       (s_coord_y),
        .s_dir_x         (s_dir_x),
        .s_dir_y         (s_dir_y),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_visible_count (m_visible_count)
    );

endmodule

// File: design/vcpc_ctrl.sv
// vcpc_ctrl: sequencer for point writes and count queries
// depends on vcpc_pkg
module vcpc_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_req_type,
    input  logic [vcpc_pkg::IDX_W-1:0]   s_point_index,
    input  vcpc_pkg::vcpc_sts_t          sts,
    output vcpc_pkg::vcpc_cmd_t          cmd
);

    vcpc_pkg::state_t                 state_reg, state_next;
    logic [vcpc_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic                             idx_in_range;

    assign idx_in_range = ({1'b0, s_point_index} < (vcpc_pkg::IDX_W + 1)'(vcpc_pkg::MAX_POINTS));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vcpc_pkg::ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        s_ready         = 1'b0;
        cmd             = '0;
        cmd.rd_addr     = idx_reg[vcpc_pkg::ADDR_W-1:0];
        case (state_reg)
            vcpc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_req_type == vcpc_pkg::REQ_QUERY) begin
                        cmd.load_query = 1'b1;
                        state_next     = vcpc_pkg::ST_ROT_MUL;
                    end else begin
                        cmd.wr_point = idx_in_range;
                    end
                end
            end
            vcpc_pkg::ST_ROT_MUL: begin
                cmd.rot_mul     = 1'b1;
                cmd.clear_count = 1'b1;
                idx_next        = '0;
                state_next      = vcpc_pkg::ST_ROT_SUM;
            end
            vcpc_pkg::ST_ROT_SUM: begin
                cmd.rot_sum = 1'b1;
                if (sts.limit == '0) begin
                    state_next = vcpc_pkg::ST_DRAIN;
                end else begin
                    state_next = vcpc_pkg::ST_SWEEP;
                end
            end
            vcpc_pkg::ST_SWEEP: begin
                cmd.issue = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_next == sts.limit) begin
                    state_next = vcpc_pkg::ST_DRAIN;
                end
            end
            vcpc_pkg::ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = vcpc_pkg::ST_DONE;
                end
            end
            vcpc_pkg::ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = vcpc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vcpc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/vcpc_dp.sv
// vcpc_dp: config registers, point memory, edge rotation and the
// per-point distance and cross product pipeline; depends on vcpc_pkg
module vcpc_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [vcpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vcpc_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [vcpc_pkg::IDX_W-1:0]         s_point_index,
    input  logic signed [vcpc_pkg::COORD_W-1:0] s_coord_x,
    input  logic signed [vcpc_pkg::COORD_W-1:0] s_coord_y,
    input  logic signed [vcpc_pkg::COORD_W-1:0] s_dir_x,
    input  logic signed [vcpc_pkg::COORD_W-1:0] s_dir_y,
    input  vcpc_pkg::vcpc_cmd_t                cmd,
    output vcpc_pkg::vcpc_sts_t                sts,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [vcpc_pkg::CNT_W-1:0]         m_visible_count
);

    localparam int CW = vcpc_pkg::COORD_W;
    localparam int OW = vcpc_pkg::OFS_W;
    localparam int PW = vcpc_pkg::PROD_W;
    localparam int EW = vcpc_pkg::EDGE_W;
    localparam int XW = vcpc_pkg::CROSS_W;
    localparam int NW = vcpc_pkg::CNT_W;

    // configuration
    logic signed [CW-1:0]                cos_reg;
    logic [vcpc_pkg::SIN_W-1:0]          sin_reg;
    logic [vcpc_pkg::RAD_W-1:0]          radius_reg;
    logic [NW-1:0]                       pcount_reg;

    // query operands
    logic signed [CW-1:0] obs_x_reg, obs_y_reg, dir_x_reg, dir_y_reg;
    logic signed [CW-1:0] sin_s;

    // rotation
    logic signed [PW-1:0] dxc_reg, dys_reg, dyc_reg, dxs_reg;
    logic signed [EW-1:0] lx_reg, ly_reg, rx_reg, ry_reg;

    // point memory, x in the upper half
    logic [2*CW-1:0]      point_mem [vcpc_pkg::MAX_POINTS];
    logic [2*CW-1:0]      rd_data_reg;

    // per-point pipeline
    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [OW-1:0] nx_reg, ny_reg;
    logic signed [vcpc_pkg::SQ_W-1:0] sqx, sqy;
    logic [vcpc_pkg::RAD_W-1:0]       sqx_reg, sqy_reg;
    logic signed [XW-2:0] lny, lynx, rny, rynx;
    logic signed [XW-2:0] lny_reg, lynx_reg, rny_reg, rynx_reg;
    logic [vcpc_pkg::D2_W-1:0] d2;
    logic signed [XW-1:0] cl, cr;
    logic                 hit_reg;

    logic [NW-1:0]        count_reg;
    logic                 m_valid_reg;
    logic [NW-1:0]        out_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cos_reg    <= '0;
            sin_reg    <= '0;
            radius_reg <= vcpc_pkg::RAD_W'(262144);
            pcount_reg <= '0;
        end else if (cfg_wr_en) begin
            case (vcpc_pkg::cfg_reg_t'(cfg_index))
                vcpc_pkg::REG_COS_HALF:  cos_reg    <= cfg_wdata[CW-1:0];
                vcpc_pkg::REG_SIN_HALF:  sin_reg    <= cfg_wdata[vcpc_pkg::SIN_W-1:0];
                vcpc_pkg::REG_RADIUS_SQ: radius_reg <= cfg_wdata[vcpc_pkg::RAD_W-1:0];
                vcpc_pkg::REG_POINT_CNT: pcount_reg <= cfg_wdata[NW-1:0];
                default: ;
            endcase
        end
    end

    assign sts.limit = (pcount_reg > NW'(vcpc_pkg::MAX_POINTS)) ?
                       NW'(vcpc_pkg::MAX_POINTS) : pcount_reg;
    assign sts.pipe_busy = v1_reg | v2_reg | v3_reg | v4_reg;
    assign sts.out_free  = !m_valid_reg || m_ready;

    // point table
    always_ff @(posedge aclk) begin
        if (cmd.wr_point) begin
            point_mem[s_point_index[vcpc_pkg::ADDR_W-1:0]] <= {s_coord_x, s_coord_y};
        end
        rd_data_reg <= point_mem[cmd.rd_addr];
    end

    assign sin_s = {1'b0, sin_reg};

    // edge vectors: left rotated by +angle, right by -angle
    always_ff @(posedge aclk) begin
        if (cmd.load_query) begin
            obs_x_reg <= s_coord_x;
            obs_y_reg <= s_coord_y;
            dir_x_reg <= s_dir_x;
            dir_y_reg <= s_dir_y;
        end
        if (cmd.rot_mul) begin
            dxc_reg <= dir_x_reg * cos_reg;
            dys_reg <= dir_y_reg * sin_s;
            dyc_reg <= dir_y_reg * cos_reg;
            dxs_reg <= dir_x_reg * sin_s;
        end
        if (cmd.rot_sum) begin
            lx_reg <= {dxc_reg[PW-1], dxc_reg} - {dys_reg[PW-1], dys_reg};
            ly_reg <= {dyc_reg[PW-1], dyc_reg} + {dxs_reg[PW-1], dxs_reg};
            rx_reg <= {dxc_reg[PW-1], dxc_reg} + {dys_reg[PW-1], dys_reg};
            ry_reg <= {dyc_reg[PW-1], dyc_reg} - {dxs_reg[PW-1], dxs_reg};
        end
    end

    assign sqx  = nx_reg * nx_reg;
    assign sqy  = ny_reg * ny_reg;
    assign lny  = lx_reg * ny_reg;
    assign lynx = ly_reg * nx_reg;
    assign rny  = rx_reg * ny_reg;
    assign rynx = ry_reg * nx_reg;

    assign d2 = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign cl = {lny_reg[XW-2], lny_reg} - {lynx_reg[XW-2], lynx_reg};
    assign cr = {rny_reg[XW-2], rny_reg} - {rynx_reg[XW-2], rynx_reg};

    always_ff @(posedge aclk) begin
        nx_reg   <= {rd_data_reg[2*CW-1], rd_data_reg[2*CW-1:CW]} -
                    {obs_x_reg[CW-1], obs_x_reg};
        ny_reg   <= {rd_data_reg[CW-1], rd_data_reg[CW-1:0]} -
                    {obs_y_reg[CW-1], obs_y_reg};
        sqx_reg  <= sqx[vcpc_pkg::RAD_W-1:0];
        sqy_reg  <= sqy[vcpc_pkg::RAD_W-1:0];
        lny_reg  <= lny;
        lynx_reg <= lynx;
        rny_reg  <= rny;
        rynx_reg <= rynx;
        hit_reg  <= (d2 <= {1'b0, radius_reg}) && cl[XW-1] && !cr[XW-1] && (cr != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // saturating point counter
    always_ff @(posedge aclk) begin
        if (cmd.clear_count) begin
            count_reg <= '0;
        end else if (v4_reg && hit_reg && (count_reg != '1)) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_count_reg <= count_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_visible_count = out_count_reg;

endmodule

// File: design/vcpc_chk.sv
// vcpc_chk: port level checks for the view cone point counter
// depends on vcpc_pkg; bound to view_cone_point_counter
module vcpc_chk (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic                          s_req_type,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [vcpc_pkg::CNT_W-1:0]    m_visible_count
);

    // no result straight out of reset
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a waiting count stays put
    a_out_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_visible_count))
        else $error("result dropped or changed while stalled");

    // the count never exceeds the table depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_visible_count <= vcpc_pkg::CNT_W'(vcpc_pkg::MAX_POINTS)))
        else $error("count above table depth");

    // a point write makes no result
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == vcpc_pkg::REQ_WRITE) && !m_valid |=> !m_valid)
        else $error("result after a point write");

    // queries are never taken while one is in flight
    a_one_query: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == vcpc_pkg::REQ_QUERY) |=> !s_ready)
        else $error("item accepted during a query");

endmodule

bind view_cone_point_counter vcpc_chk u_vcpc_chk (.*);
